>>> src/pli_pkg.sv
package pli_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned IndexW   = 6;
  localparam int unsigned CountW   = 7;
  localparam int unsigned MagW     = CoordW + 1;
  localparam int unsigned ProdW    = 2 * MagW;
  localparam int unsigned MulSteps = MagW;
  localparam int unsigned DivSteps = ProdW;
  localparam int unsigned StepW    = 7;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  localparam logic [0:0] RegNodeCount = 1'b0;

  localparam logic [CountW-1:0] NodeCountReset = CountW'(2);

  typedef enum logic [0:0] {
    CmdLoad = 1'b0,
    CmdEval = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusZeroWidth = 2'd1,
    StatusFewNodes  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                     command;
    logic [IndexW-1:0]        node_index;
    logic signed [CoordW-1:0] node_x;
    logic signed [CoordW-1:0] node_y;
    logic signed [CoordW-1:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] value;
    status_e                  status;
    logic [IndexW-1:0]        segment;
  } out_item_t;

endpackage

>>> src/piecewise_linear_interpolator_core.sv
// Piecewise linear interpolator over a breakpoint table of MAX_NODES entries. A load transfer
// writes one (x, y) node; slots at or beyond MAX_NODES are dropped, and a load gives no result.
// An evaluate transfer gives one result: the first segment whose right node exceeds the query
// (else the last), with y0 + (y1-y0)*(q-x0)/(x1-x0) truncated toward zero and saturated to
// 32 bits. node_count sets the nodes in use; the user must write it over the APB port only while
// the block is idle, which the block itself does not enforce. Only written nodes may be read by a
// query. One item is worked at a time; the input stalls while an evaluation runs. An evaluation
// runs a linear scan over the table memory, a node fetch, a bit-serial multiplier and a bit-serial
// restoring divider; fewer than two nodes give a result without a scan, and a zero-width segment
// finishes right after the scan and fetch. A load does not stall the input.
module piecewise_linear_interpolator_core #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pli_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pli_pkg::out_item_t             out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pli_pkg::AddrW-1:0]      paddr,
  input  logic [pli_pkg::DataW-1:0]      pwdata,
  output logic [pli_pkg::DataW-1:0]      prdata,
  output logic                           pready
);
  import pli_pkg::*;

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SScan   = 4'd1;
  localparam logic [3:0] SCmp    = 4'd2;
  localparam logic [3:0] SFetch0 = 4'd3;
  localparam logic [3:0] SFetch1 = 4'd4;
  localparam logic [3:0] SDiff   = 4'd5;
  localparam logic [3:0] SMul    = 4'd6;
  localparam logic [3:0] SDiv    = 4'd7;
  localparam logic [3:0] SFin    = 4'd8;
  localparam logic [3:0] SOut    = 4'd9;

  logic [CoordW-1:0] abs_mem [MAX_NODES];
  logic [CoordW-1:0] ord_mem [MAX_NODES];
  logic [CoordW-1:0] rd_x_q, rd_y_q;

  logic [3:0]               state_q, state_d;
  logic [AW-1:0]            j_q, j_d;
  logic [CW-1:0]            n_q, n_d;
  logic signed [CoordW-1:0] qx_q, qx_d;
  logic signed [CoordW-1:0] x0_q, x0_d;
  logic signed [CoordW-1:0] y0_q, y0_d;
  logic [MagW-1:0]          md_q, md_d;
  logic [MagW-1:0]          dv_q, dv_d;
  logic [MagW-1:0]          rem_q, rem_d;
  logic [ProdW-1:0]         prod_q, prod_d;
  logic [StepW-1:0]         cnt_q, cnt_d;
  logic                     neg_q, neg_d;
  out_item_t                res_q, res_d;
  out_item_t                out_q, out_d;
  logic                     out_valid_q, out_valid_d;
  logic [CountW-1:0]        node_count_q, node_count_d;

  logic                     in_xfer, out_xfer, cfg_wr, mem_we;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [CW-1:0]            n_clamp;
  logic                     scan_more;
  logic signed [MagW-1:0]   dx, dy, dq;
  logic [MagW-1:0]          dx_mag, dy_mag, dq_mag;
  logic [MagW:0]            mul_sum;
  logic [MagW:0]            div_t, div_diff;
  logic                     div_ge;
  logic signed [MagW:0]     fin_sum;
  logic                     fin_big;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && (paddr[2] == RegNodeCount);
  assign prdata      = (paddr[2] == RegNodeCount) ? DataW'(node_count_q) : '0;
  assign in_stall_o  = (state_q != SIdle);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_xfer    = out_valid_q && !out_stall_i;

  assign mem_waddr = AW'(in_data_i.node_index);
  assign mem_we    = in_xfer && (in_data_i.command == CmdLoad) &&
                     (32'(in_data_i.node_index) < MAX_NODES);

  always_comb begin
    unique case (state_q)
      SScan, SFetch1: mem_raddr = j_q + AW'(1);
      default:        mem_raddr = j_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      abs_mem[mem_waddr] <= in_data_i.node_x;
      ord_mem[mem_waddr] <= in_data_i.node_y;
    end
    rd_x_q <= abs_mem[mem_raddr];
    rd_y_q <= ord_mem[mem_raddr];
  end

  assign n_clamp   = (32'(node_count_q) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count_q);
  assign scan_more = ((CW+1)'(j_q) + (CW+1)'(2)) < {1'b0, n_q};

  assign dx = $signed({rd_x_q[CoordW-1], rd_x_q}) - $signed({x0_q[CoordW-1], x0_q});
  assign dy = $signed({rd_y_q[CoordW-1], rd_y_q}) - $signed({y0_q[CoordW-1], y0_q});
  assign dq = $signed({qx_q[CoordW-1], qx_q}) - $signed({x0_q[CoordW-1], x0_q});
  assign dx_mag = dx[MagW-1] ? MagW'(-dx) : MagW'(dx);
  assign dy_mag = dy[MagW-1] ? MagW'(-dy) : MagW'(dy);
  assign dq_mag = dq[MagW-1] ? MagW'(-dq) : MagW'(dq);

  // shift-add multiplier, one multiplier bit a cycle
  assign mul_sum = {1'b0, prod_q[ProdW-1:MagW]} + (prod_q[0] ? {1'b0, md_q} : '0);

  // restoring divider, one quotient bit a cycle, quotient shifts into prod_q
  assign div_t    = {rem_q, prod_q[ProdW-1]};
  assign div_ge   = div_t >= {1'b0, dv_q};
  assign div_diff = div_t - {1'b0, dv_q};

  assign fin_big = |prod_q[ProdW-1:CoordW];
  assign fin_sum = neg_q ?
      $signed({{2{y0_q[CoordW-1]}}, y0_q}) - $signed({2'b00, prod_q[CoordW-1:0]}) :
      $signed({{2{y0_q[CoordW-1]}}, y0_q}) + $signed({2'b00, prod_q[CoordW-1:0]});

  always_comb begin
    state_d      = state_q;
    j_d          = j_q;
    n_d          = n_q;
    qx_d         = qx_q;
    x0_d         = x0_q;
    y0_d         = y0_q;
    md_d         = md_q;
    dv_d         = dv_q;
    rem_d        = rem_q;
    prod_d       = prod_q;
    cnt_d        = cnt_q;
    neg_d        = neg_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_xfer;
    node_count_d = cfg_wr ? pwdata[CountW-1:0] : node_count_q;

    unique case (state_q)
      SIdle: begin
        if (in_xfer && (in_data_i.command == CmdEval)) begin
          qx_d = in_data_i.query_x;
          n_d  = n_clamp;
          j_d  = '0;
          if (n_clamp < CW'(2)) begin
            res_d.value   = '0;
            res_d.status  = StatusFewNodes;
            res_d.segment = '0;
            state_d       = SOut;
          end else begin
            state_d = SScan;
          end
        end
      end
      SScan: begin
        state_d = scan_more ? SCmp : SFetch0;
      end
      SCmp: begin
        if (qx_q < $signed(rd_x_q)) begin
          state_d = SFetch0;
        end else begin
          j_d     = j_q + AW'(1);
          state_d = SScan;
        end
      end
      SFetch0: begin
        state_d = SFetch1;
      end
      SFetch1: begin
        x0_d    = rd_x_q;
        y0_d    = rd_y_q;
        state_d = SDiff;
      end
      SDiff: begin
        res_d.segment = IndexW'(j_q);
        if (dx == '0) begin
          res_d.value  = y0_q;
          res_d.status = StatusZeroWidth;
          state_d      = SOut;
        end else begin
          md_d    = dy_mag;
          dv_d    = dx_mag;
          prod_d  = {{MagW{1'b0}}, dq_mag};
          neg_d   = dy[MagW-1] ^ dq[MagW-1] ^ dx[MagW-1];
          cnt_d   = '0;
          state_d = SMul;
        end
      end
      SMul: begin
        prod_d = {mul_sum, prod_q[MagW-1:1]};
        cnt_d  = cnt_q + StepW'(1);
        if (cnt_q == StepW'(MulSteps - 1)) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = SDiv;
        end
      end
      SDiv: begin
        rem_d  = div_ge ? div_diff[MagW-1:0] : div_t[MagW-1:0];
        prod_d = {prod_q[ProdW-2:0], div_ge};
        cnt_d  = cnt_q + StepW'(1);
        if (cnt_q == StepW'(DivSteps - 1)) begin
          state_d = SFin;
        end
      end
      SFin: begin
        res_d.status = StatusOk;
        if (fin_big) begin
          res_d.value = neg_q ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
        end else if (fin_sum[MagW] != fin_sum[CoordW-1] || fin_sum[MagW] != fin_sum[MagW-1])
        begin
          res_d.value = fin_sum[MagW] ? {1'b1, {(CoordW-1){1'b0}}} :
                                        {1'b0, {(CoordW-1){1'b1}}};
        end else begin
          res_d.value = fin_sum[CoordW-1:0];
        end
        state_d = SOut;
      end
      SOut: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      out_valid_q  <= 1'b0;
      node_count_q <= NodeCountReset;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      node_count_q <= node_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q    <= j_d;
    n_q    <= n_d;
    qx_q   <= qx_d;
    x0_q   <= x0_d;
    y0_q   <= y0_d;
    md_q   <= md_d;
    dv_q   <= dv_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  a_eval_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.command == CmdEval) |=> (state_q != SIdle))
    else $error("evaluate transfer did not start work");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == SOut))
    else $error("result appeared outside the output step");

  a_few_nodes_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == StatusFewNodes) |->
      (out_data_o.value == '0 && out_data_o.segment == '0))
    else $error("too-few-nodes result carries data");

  a_segment_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((32'(out_data_o.segment) + 32'd2) <= MAX_NODES))
    else $error("segment beyond table");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pli_pkg::*;

  localparam int MaxNodes    = 64;
  localparam int DrainCycles = 250;
  localparam int LongHold    = 800;
  localparam int QuietLimit  = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  piecewise_linear_interpolator_core #(.MAX_NODES(MaxNodes)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  // breakpoint table and register as the block should hold them
  logic signed [31:0] abscissa [MaxNodes];
  logic signed [31:0] ordinate [MaxNodes];
  logic [CountW-1:0] node_count_m = NodeCountReset;

  // stimulus-side view of the table, used to aim queries
  bit signed [31:0] plan_x [MaxNodes];

  in_item_t queued_items[$];
  out_item_t awaited_results[$];

  int mismatches = 0;
  int loads_seen = 0;
  int evals_seen = 0;
  int config_writes = 0;
  int results_checked = 0;
  int ok_results = 0;
  int zero_width_results = 0;
  int few_node_results = 0;

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sh7fff_ffff) return 32'h7fff_ffff;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic out_item_t interpolate_at(logic signed [31:0] q);
    out_item_t r;
    int n, seg;
    longint x0, x1, y0, y1, dx, dy, dq, total;
    logic [63:0] mag_dx, mag_dy, mag_dq;
    logic [67:0] quot;
    bit neg;
    n = (node_count_m > MaxNodes) ? MaxNodes : int'(node_count_m);
    r.value = '0;
    r.status = StatusFewNodes;
    r.segment = '0;
    if (n < 2) return r;
    seg = 0;
    while (seg + 2 < n && q >= abscissa[seg + 1]) seg++;
    x0 = abscissa[seg];
    x1 = abscissa[seg + 1];
    y0 = ordinate[seg];
    y1 = ordinate[seg + 1];
    dx = x1 - x0;
    r.segment = IndexW'(seg);
    if (dx == 0) begin
      r.value = y0[31:0];
      r.status = StatusZeroWidth;
      return r;
    end
    dy = y1 - y0;
    dq = q - x0;
    neg = ((dy < 0) != (dq < 0)) != (dx < 0);
    mag_dx = (dx < 0) ? -dx : dx;
    mag_dy = (dy < 0) ? -dy : dy;
    mag_dq = (dq < 0) ? -dq : dq;
    quot = ({4'b0, mag_dy} * {4'b0, mag_dq}) / {4'b0, mag_dx};
    // a quotient past the cap saturates the result either way, so pin it to keep it in range
    if (quot >= 68'h200_0000_0000) quot = 68'h100_0000_0000;
    total = neg ? y0 - longint'(quot[41:0]) : y0 + longint'(quot[41:0]);
    r.value = clamp32(total);
    r.status = StatusOk;
    return r;
  endfunction

  function automatic logic [31:0] random_coord();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
  endfunction

  task automatic push_load(int idx, logic [31:0] x, logic [31:0] y);
    in_item_t item;
    item.command = CmdLoad;
    item.node_index = IndexW'(idx);
    item.node_x = x;
    item.node_y = y;
    item.query_x = $urandom;
    plan_x[idx] = x;
    queued_items.push_back(item);
  endtask

  task automatic push_eval(logic [31:0] q);
    in_item_t item;
    item.command = CmdEval;
    item.node_index = IndexW'($urandom);
    item.node_x = $urandom;
    item.node_y = $urandom;
    item.query_x = q;
    queued_items.push_back(item);
  endtask

  task automatic push_query(int n);
    int k;
    longint q, right;
    k = $urandom_range(0, (n < 2) ? 0 : n - 1);
    q = plan_x[k];
    right = (k + 1 < n) ? longint'(plan_x[k + 1]) : q + 64'sh1_0000;
    case ($urandom_range(0, 5))
      0: ;
      1: q = q + longint'($urandom_range(0, 512)) - 256;
      2: q = q + (right - q) * longint'($urandom_range(0, 1023)) / 1024;
      3: q = $signed($urandom);
      4: q = $urandom_range(0, 1) ? -64'sh8000_0000 : 64'sh7fff_ffff;
      default: q = q + (right - q) * longint'($urandom_range(2, 40));
    endcase
    push_eval(clamp32(q));
  endtask

  task automatic load_table(int n);
    int style;
    longint x, stride;
    style = $urandom_range(0, 3);
    x = longint'($urandom_range(0, 32'h0020_0000)) - 64'sh10_0000;
    stride = 64'sh1_0000_0000 / n;
    for (int k = 0; k < n; k++) begin
      case (style)
        0, 1: begin
          // style 1 leaves some neighbors equal to get zero-width segments
          if (k > 0 && !(style == 1 && $urandom_range(0, 3) == 0))
            x = x + longint'($urandom_range(1, 32'h0002_0000));
        end
        2: x = -64'sh8000_0000 + k * stride + longint'($urandom_range(0, 32'(stride / 2)));
        default: x = $signed($urandom);
      endcase
      push_load(k, clamp32(x), random_coord());
    end
  endtask

  task automatic set_node_count(int unsigned value);
    logic [AddrW-1:0] addr;
    addr = AddrW'(RegNodeCount) << 2;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    node_count_m = CountW'(value);
    config_writes++;
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== DataW'(value)) begin
      mismatches++;
      $display("%0t node_count readback mismatch: expected %h actual %h",
               $time, DataW'(value), prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (queued_items.size() != 0 || in_valid_i || awaited_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // sender: bursts of transfers separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (in_valid_i) begin
        if (in_data_i.command == CmdLoad) begin
          abscissa[in_data_i.node_index] = in_data_i.node_x;
          ordinate[in_data_i.node_index] = in_data_i.node_y;
          loads_seen++;
        end else begin
          awaited_results.push_back(interpolate_at(in_data_i.query_x));
          evals_seen++;
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (queued_items.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= queued_items.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: checks results and stalls on its own pattern
  out_item_t want;
  int hold_left = 0;
  int stall_mode = 0;
  int stall_timer = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: expected none, actual %h", $time, out_data_o);
        end else begin
          want = awaited_results.pop_front();
          if (out_data_o.value !== want.value) begin
            mismatches++;
            $display("%0t value mismatch: expected %h actual %h",
                     $time, want.value, out_data_o.value);
          end
          if (out_data_o.status !== want.status) begin
            mismatches++;
            $display("%0t status mismatch: expected %0d actual %0d",
                     $time, want.status, out_data_o.status);
          end
          if (out_data_o.segment !== want.segment) begin
            mismatches++;
            $display("%0t segment mismatch: expected %0d actual %0d",
                     $time, want.segment, out_data_o.segment);
          end
          case (want.status)
            StatusOk: ok_results++;
            StatusZeroWidth: zero_width_results++;
            default: few_node_results++;
          endcase
          results_checked++;
          // long hold so the block backs up and stalls its input
          if (results_checked == 40 || results_checked == 700) hold_left = LongHold;
        end
      end
      if (stall_timer == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_timer = $urandom_range(50, 400);
      end else begin
        stall_timer--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= $urandom_range(0, 1);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == QuietLimit) begin
      $display("timeout: no transfer for %0d cycles", QuietLimit);
      $display("** piecewise_linear_interpolator_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned count_plan [13];
    int n_eff;
    int slot;
    count_plan = '{64, 0, 1, 127, 3, 65, 2, 17, 5, 63, 33, 4, 9};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset value of node_count: two nodes
    push_load(0, 32'h0000_0000, 32'h0000_0000);
    push_load(1, 32'h0001_0000, 32'h0002_0000);
    push_eval(32'h0000_8000);
    push_eval(32'h0001_0000);
    push_eval(32'h8000_0000);
    push_eval(32'h7fff_ffff);
    push_eval(32'h0000_0000);
    push_load(0, 32'h8000_0000, 32'h7fff_ffff);
    push_load(1, 32'h7fff_ffff, 32'h8000_0000);
    push_eval(32'h0000_0000);
    push_eval(32'h8000_0000);
    push_eval(32'h7fff_ffff);
    push_eval(32'h4000_0000);
    push_load(1, 32'h8000_0000, 32'h1234_5678);
    push_eval(32'h0000_0005);
    push_load(63, 32'h7fff_ffff, 32'h8000_0000);
    push_load(0, 32'hffff_0000, 32'hfffd_0000);
    push_load(1, 32'h0003_0000, 32'h0007_0000);
    push_eval(32'hfffe_0000);
    push_eval(32'h0000_0001);

    foreach (count_plan[p]) begin
      wait_drained();
      set_node_count(count_plan[p]);
      n_eff = (count_plan[p] > MaxNodes) ? MaxNodes : int'(count_plan[p]);
      if (n_eff >= 2) load_table(n_eff);
      repeat (110) begin
        if ($urandom_range(0, 9) < 3) begin
          slot = $urandom_range(0, MaxNodes - 1);
          push_load(slot, ($urandom_range(0, 3) == 0) ? $urandom : plan_x[slot],
                    random_coord());
        end else begin
          push_query(n_eff);
        end
      end
    end
    wait_drained();

    $display("ran %0d load and %0d evaluate transfers over %0d node_count writes",
             loads_seen, evals_seen, config_writes);
    $display("results: %0d interpolated, %0d zero-width, %0d too few nodes",
             ok_results, zero_width_results, few_node_results);
    if (mismatches == 0) begin
      $display("** piecewise_linear_interpolator_core: PASSED **");
    end else begin
      $display("** piecewise_linear_interpolator_core: FAILED **");
    end
    $finish;
  end

endmodule
